// File: rtl/lts_pkg.sv
// ----------------------------------------------------------------------------
// Lexer token scanner package
// Shared types, token kinds, scanner states, character codes and keywords.
// ----------------------------------------------------------------------------
package lts_pkg;

  typedef enum logic [4:0] {
    K_IDENT    = 5'd0,
    K_INT      = 5'd1,
    K_REAL     = 5'd2,
    K_STRING   = 5'd3,
    K_TYPE     = 5'd4,
    K_ADD      = 5'd5,
    K_MUL      = 5'd6,
    K_REL      = 5'd7,
    K_OR       = 5'd8,
    K_AND      = 5'd9,
    K_NOT      = 5'd10,
    K_EQUALITY = 5'd11,
    K_SEMI     = 5'd12,
    K_COMMA    = 5'd13,
    K_LPAREN   = 5'd14,
    K_RPAREN   = 5'd15,
    K_LBRACE   = 5'd16,
    K_RBRACE   = 5'd17,
    K_ASSIGN   = 5'd18,
    K_IF       = 5'd19,
    K_WHILE    = 5'd20,
    K_RETURN   = 5'd21,
    K_ELSE     = 5'd22,
    K_END      = 5'd23,
    K_ERROR    = 5'd24
  } token_kind_t;

  typedef enum logic [3:0] {
    ST_START,
    ST_INT,
    ST_DOT,
    ST_REAL,
    ST_REL,
    ST_BAR,
    ST_AMP,
    ST_NOT,
    ST_ASSIGN,
    ST_IDENT,
    ST_QUOTE,
    ST_STRBODY
  } scan_state_t;

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_input;
  } char_word_t;

  typedef struct packed {
    token_kind_t token_kind;
    logic [7:0]  token_length;
    logic        last_of_item;
  } token_t;

  typedef struct packed {
    scan_state_t state;
    logic [7:0]  length;
  } scan_regs_t;

  localparam int TOKEN_FIFO_DEPTH = 4;

  localparam logic [7:0] CH_END    = 8'h24;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  // Keywords packed with the first character in the low byte.
  localparam logic [47:0] WORD_INT    = 48'h00_00_00_74_6E_69;
  localparam logic [47:0] WORD_FLOAT  = 48'h00_74_61_6F_6C_66;
  localparam logic [47:0] WORD_VOID   = 48'h00_00_64_69_6F_76;
  localparam logic [47:0] WORD_IF     = 48'h00_00_00_00_66_69;
  localparam logic [47:0] WORD_WHILE  = 48'h00_65_6C_69_68_77;
  localparam logic [47:0] WORD_RETURN = 48'h6E_72_75_74_65_72;
  localparam logic [47:0] WORD_ELSE   = 48'h00_00_65_73_6C_65;

endpackage

// File: rtl/lts_if.sv
// ----------------------------------------------------------------------------
// Lexer token scanner channel
// Valid/ready channel that moves one word of the given payload type.
// ----------------------------------------------------------------------------
interface lts_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/lexer_token_scanner.sv
// ----------------------------------------------------------------------------
// Lexer token scanner
// Character-at-a-time scanning automaton that emits token kinds and lengths.
// ----------------------------------------------------------------------------
//  channel   dir   word         fields
//  chars     in    char_word_t  character[7:0], end_of_input
//  tokens    out   token_t      token_kind[4:0], token_length[7:0], last_of_item
//
// A character is taken when chars.valid and chars.ready are both high;
// its state update and tokens are done in that cycle, and the tokens land
// in a four-word output queue. The queue sends one token a cycle while
// tokens.ready is high; chars.ready drops when fewer than two queue words
// are free. Synchronous reset returns the automaton to its start state and
// empties the queue.
// ----------------------------------------------------------------------------
module lexer_token_scanner import lts_pkg::*; #(
  parameter int KEYWORD_CHARS = 6
) (
  input logic clk,
  input logic rst,
  lts_if.sink   chars,
  lts_if.source tokens
);

  scan_regs_t                 regs;
  scan_regs_t                 regs_next;
  logic [8*KEYWORD_CHARS-1:0] kwbuf;
  logic [8*KEYWORD_CHARS-1:0] kwbuf_next;
  logic [1:0]                 tok_count;
  token_t                     tok0;
  token_t                     tok1;
  logic                       room_for_two;
  logic                       accept;
  char_word_t                 in_word;
  token_t                     out_word;

  assign in_word      = chars.data;
  assign chars.ready  = room_for_two;
  assign accept       = chars.valid && room_for_two;
  assign tokens.data  = out_word;

  lts_scan #(
    .KeywordChars(KEYWORD_CHARS)
  ) u_scan (
    .regs       (regs),
    .kwbuf      (kwbuf),
    .word       (in_word),
    .regs_next  (regs_next),
    .kwbuf_next (kwbuf_next),
    .tok_count  (tok_count),
    .tok0       (tok0),
    .tok1       (tok1)
  );

  lts_fifo u_fifo (
    .clk          (clk),
    .rst          (rst),
    .push_count   (accept ? tok_count : 2'd0),
    .push0        (tok0),
    .push1        (tok1),
    .room_for_two (room_for_two),
    .out_valid    (tokens.valid),
    .out_ready    (tokens.ready),
    .out_word     (out_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.state  <= ST_START;
      regs.length <= 8'd0;
      kwbuf       <= '0;
    end else if (accept) begin
      regs  <= regs_next;
      kwbuf <= kwbuf_next;
    end
  end

endmodule

// File: rtl/lts_scan.sv
// ----------------------------------------------------------------------------
// Lexer token scanner step
// Next state of the scanning automaton and the tokens one character causes.
// ----------------------------------------------------------------------------
module lts_scan import lts_pkg::*; #(
  parameter int KeywordChars = 6
) (
  input  scan_regs_t                    regs,
  input  logic [8*KeywordChars-1:0]     kwbuf,
  input  char_word_t                    word,
  output scan_regs_t                    regs_next,
  output logic [8*KeywordChars-1:0]     kwbuf_next,
  output logic [1:0]                    tok_count,
  output token_t                        tok0,
  output token_t                        tok1
);

  localparam int KW = 8 * KeywordChars;

  logic [7:0]       c;
  logic             letter;
  logic             digit;
  logic             blank;
  logic [7:0]       longer;
  logic [KW-1:0]    kw_taken;
  token_kind_t      ident_kind;
  logic             have_a;
  token_kind_t      kind_a;
  logic [7:0]       len_a;
  logic             have_b;
  token_kind_t      kind_b;
  logic             rescan;
  scan_state_t      st;
  logic [7:0]       ln;
  logic [KW-1:0]    kb;

  function automatic logic word_is(input logic [KW-1:0] buf_v, input logic [7:0] len_v,
                                   input logic [47:0] word_v, input logic [7:0] n);
    return (len_v == n) && (buf_v == KW'(word_v));
  endfunction

  assign c      = word.end_of_input ? CH_END : word.character;
  assign letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == CH_UNDER;
  assign digit  = c >= 8'h30 && c <= 8'h39;
  assign blank  = c == CH_SPACE || c == CH_TAB;
  assign longer = (regs.length == 8'hFF) ? regs.length : regs.length + 8'd1;

  always_comb begin
    kw_taken = kwbuf;
    for (int i = 0; i < KeywordChars; i++) begin
      if (regs.length == 8'(i)) begin
        kw_taken[8*i +: 8] = c;
      end
    end
  end

  always_comb begin
    if (word_is(kwbuf, regs.length, WORD_INT, 8'd3) ||
        word_is(kwbuf, regs.length, WORD_FLOAT, 8'd5) ||
        word_is(kwbuf, regs.length, WORD_VOID, 8'd4)) begin
      ident_kind = K_TYPE;
    end else if (word_is(kwbuf, regs.length, WORD_IF, 8'd2)) begin
      ident_kind = K_IF;
    end else if (word_is(kwbuf, regs.length, WORD_WHILE, 8'd5)) begin
      ident_kind = K_WHILE;
    end else if (word_is(kwbuf, regs.length, WORD_RETURN, 8'd6)) begin
      ident_kind = K_RETURN;
    end else if (word_is(kwbuf, regs.length, WORD_ELSE, 8'd4)) begin
      ident_kind = K_ELSE;
    end else begin
      ident_kind = K_IDENT;
    end
  end

  always_comb begin
    have_a = 1'b0;
    kind_a = K_ERROR;
    len_a  = regs.length;
    rescan = 1'b0;
    st     = regs.state;
    ln     = regs.length;
    kb     = kwbuf;

    // An open token either absorbs the character, completes with it, or
    // closes and hands the character back to the start state.
    unique case (regs.state)
      ST_START: begin
        rescan = 1'b1;
      end
      ST_INT: begin
        if (digit) begin
          ln = longer;
        end else if (c == CH_DOT) begin
          st = ST_DOT;
          ln = longer;
        end else begin
          have_a = 1'b1;
          kind_a = K_INT;
          rescan = 1'b1;
        end
      end
      ST_DOT: begin
        if (digit) begin
          st = ST_REAL;
          ln = longer;
        end else begin
          have_a = 1'b1;
          kind_a = K_ERROR;
          rescan = 1'b1;
        end
      end
      ST_REAL: begin
        if (digit) begin
          ln = longer;
        end else begin
          have_a = 1'b1;
          kind_a = K_REAL;
          rescan = 1'b1;
        end
      end
      ST_REL: begin
        have_a = 1'b1;
        kind_a = K_REL;
        if (c == CH_EQ) begin
          len_a = longer;
        end else begin
          rescan = 1'b1;
        end
      end
      ST_BAR: begin
        have_a = 1'b1;
        if (c == CH_BAR) begin
          kind_a = K_OR;
          len_a  = longer;
        end else begin
          kind_a = K_ERROR;
          rescan = 1'b1;
        end
      end
      ST_AMP: begin
        have_a = 1'b1;
        if (c == CH_AMP) begin
          kind_a = K_AND;
          len_a  = longer;
        end else begin
          kind_a = K_ERROR;
          rescan = 1'b1;
        end
      end
      ST_NOT: begin
        have_a = 1'b1;
        if (c == CH_EQ) begin
          kind_a = K_EQUALITY;
          len_a  = longer;
        end else begin
          kind_a = K_NOT;
          rescan = 1'b1;
        end
      end
      ST_ASSIGN: begin
        have_a = 1'b1;
        if (c == CH_EQ) begin
          kind_a = K_EQUALITY;
          len_a  = longer;
        end else begin
          kind_a = K_ASSIGN;
          rescan = 1'b1;
        end
      end
      ST_IDENT: begin
        if (letter || digit) begin
          ln = longer;
          kb = kw_taken;
        end else begin
          have_a = 1'b1;
          kind_a = ident_kind;
          rescan = 1'b1;
        end
      end
      ST_QUOTE: begin
        if (letter || digit || blank) begin
          st = ST_STRBODY;
          ln = longer;
        end else begin
          have_a = 1'b1;
          kind_a = K_ERROR;
          rescan = 1'b1;
        end
      end
      ST_STRBODY: begin
        if (letter || digit || blank) begin
          ln = longer;
        end else if (c == CH_QUOTE) begin
          have_a = 1'b1;
          kind_a = K_STRING;
          len_a  = longer;
        end else begin
          have_a = 1'b1;
          kind_a = K_ERROR;
          rescan = 1'b1;
        end
      end
      default: begin
        rescan = 1'b1;
      end
    endcase

    if (have_a || rescan) begin
      st = ST_START;
      ln = 8'd0;
      kb = '0;
    end

    have_b = 1'b0;
    kind_b = K_END;
    if (rescan) begin
      unique case (c) inside
        CH_END: begin
          have_b = 1'b1;
          kind_b = K_END;
        end
        CH_QUOTE: begin
          st = ST_QUOTE;
          ln = 8'd1;
        end
        CH_PLUS, CH_MINUS: begin
          have_b = 1'b1;
          kind_b = K_ADD;
        end
        CH_STAR, CH_SLASH: begin
          have_b = 1'b1;
          kind_b = K_MUL;
        end
        CH_LT, CH_GT: begin
          st = ST_REL;
          ln = 8'd1;
        end
        CH_BAR: begin
          st = ST_BAR;
          ln = 8'd1;
        end
        CH_AMP: begin
          st = ST_AMP;
          ln = 8'd1;
        end
        CH_BANG: begin
          st = ST_NOT;
          ln = 8'd1;
        end
        CH_EQ: begin
          st = ST_ASSIGN;
          ln = 8'd1;
        end
        CH_SEMI: begin
          have_b = 1'b1;
          kind_b = K_SEMI;
        end
        CH_APOS: begin
          have_b = 1'b1;
          kind_b = K_COMMA;
        end
        CH_LPAREN: begin
          have_b = 1'b1;
          kind_b = K_LPAREN;
        end
        CH_RPAREN: begin
          have_b = 1'b1;
          kind_b = K_RPAREN;
        end
        CH_LBRACE: begin
          have_b = 1'b1;
          kind_b = K_LBRACE;
        end
        CH_RBRACE: begin
          have_b = 1'b1;
          kind_b = K_RBRACE;
        end
        default: begin
          if (letter) begin
            st = ST_IDENT;
            ln = 8'd1;
            kb = KW'(c);
          end else if (digit) begin
            st = ST_INT;
            ln = 8'd1;
          end
        end
      endcase
    end

    regs_next.state  = st;
    regs_next.length = ln;
    kwbuf_next       = kb;
  end

  always_comb begin
    tok_count = 2'(have_a) + 2'(have_b);
    if (have_a) begin
      tok0.token_kind   = kind_a;
      tok0.token_length = len_a;
      tok0.last_of_item = !have_b;
    end else begin
      tok0.token_kind   = kind_b;
      tok0.token_length = 8'd1;
      tok0.last_of_item = 1'b1;
    end
    tok1.token_kind   = kind_b;
    tok1.token_length = 8'd1;
    tok1.last_of_item = 1'b1;
  end

endmodule

// File: rtl/lts_fifo.sv
// ----------------------------------------------------------------------------
// Lexer token scanner output queue
// Queue taking up to two tokens a cycle; sends one a cycle while out_ready.
// ----------------------------------------------------------------------------
module lts_fifo import lts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_count,
  input  token_t     push0,
  input  token_t     push1,
  output logic       room_for_two,
  output logic       out_valid,
  input  logic       out_ready,
  output token_t     out_word
);

  localparam int AW = $clog2(TOKEN_FIFO_DEPTH);

  token_t        mem [TOKEN_FIFO_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          pop;

  assign pop          = out_valid && out_ready;
  assign out_valid    = count != '0;
  assign out_word     = mem[rd_ptr];
  assign room_for_two = count <= (AW+1)'(TOKEN_FIFO_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr + AW'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(push_count);
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count + (AW+1)'(push_count) - (AW+1)'(pop);
    end
  end

endmodule

// File: rtl/lts_checker.sv
// ----------------------------------------------------------------------------
// Lexer token scanner checker
// Port-level assertions on the token stream, bound to the top level.
// ----------------------------------------------------------------------------
module lts_checker import lts_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input token_kind_t token_kind,
  input logic [7:0]  token_length,
  input logic        last_of_item
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("token word offered right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable(token_kind) && $stable(token_length) && $stable(last_of_item))
    else $error("stalled token word changed or was withdrawn");

  a_nonzero_length: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> token_length != 8'd0)
    else $error("token with zero length");

  a_end_token: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == K_END |-> token_length == 8'd1 && last_of_item)
    else $error("end token must have length one and close its character");

endmodule

bind lexer_token_scanner lts_checker u_lts_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (tokens.valid),
  .out_ready    (tokens.ready),
  .token_kind   (tokens.data.token_kind),
  .token_length (tokens.data.token_length),
  .last_of_item (tokens.data.last_of_item)
);

// File: test/lts_token_checker.sv
// ----------------------------------------------------------------------------
// Token stream checker
// Watches the character and token channels of the lexer token scanner. Each
// accepted character word is run through a behavioral copy of the scanning
// automaton, and the tokens it yields are queued. Each accepted token word is
// compared field by field with the oldest queued token. The failure count and
// the number of tokens still owed by the block go back to the testbench top.
// ----------------------------------------------------------------------------
module lts_token_checker import lts_pkg::*; #(
  parameter int KEYWORD_CHARS = 6
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  input  logic       char_ready,
  input  char_word_t char_word,
  input  logic       token_valid,
  input  logic       token_ready,
  input  token_t     token_word,
  output int         fail_count,
  output int         pending
);

  localparam int SHOWN_MISMATCHES = 10;

  scan_state_t                 scan_q = ST_START;
  logic [7:0]                  length_q = '0;
  logic [8*KEYWORD_CHARS-1:0]  word_q = '0;
  int                          step_tokens = 0;
  int                          failures = 0;
  int                          token_index = 0;
  token_t                      expected_tokens[$];

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == CH_UNDER;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  function automatic token_kind_t keyword_kind();
    if ((length_q == 3 && word_q == WORD_INT) || (length_q == 5 && word_q == WORD_FLOAT) ||
        (length_q == 4 && word_q == WORD_VOID)) return K_TYPE;
    if (length_q == 2 && word_q == WORD_IF) return K_IF;
    if (length_q == 5 && word_q == WORD_WHILE) return K_WHILE;
    if (length_q == 6 && word_q == WORD_RETURN) return K_RETURN;
    if (length_q == 4 && word_q == WORD_ELSE) return K_ELSE;
    return K_IDENT;
  endfunction

  task automatic take_char(logic [7:0] c);
    if (scan_q == ST_IDENT && length_q < KEYWORD_CHARS) word_q[8*length_q +: 8] = c;
    if (length_q != 8'd255) length_q = length_q + 8'd1;
  endtask

  task automatic open_token(scan_state_t st, logic [7:0] c);
    scan_q = st;
    length_q = '0;
    word_q = '0;
    take_char(c);
  endtask

  task automatic close_token(token_kind_t kind, logic [7:0] len);
    if (step_tokens < 2) begin
      expected_tokens.push_back('{token_kind: kind, token_length: len, last_of_item: 1'b0});
      step_tokens++;
    end
    scan_q = ST_START;
    length_q = '0;
    word_q = '0;
  endtask

  task automatic start_token(logic [7:0] c);
    case (c)
      CH_END: close_token(K_END, 8'd1);
      CH_QUOTE: open_token(ST_QUOTE, c);
      CH_PLUS, CH_MINUS: close_token(K_ADD, 8'd1);
      CH_STAR, CH_SLASH: close_token(K_MUL, 8'd1);
      CH_LT, CH_GT: open_token(ST_REL, c);
      CH_BAR: open_token(ST_BAR, c);
      CH_AMP: open_token(ST_AMP, c);
      CH_BANG: open_token(ST_NOT, c);
      CH_EQ: open_token(ST_ASSIGN, c);
      CH_SEMI: close_token(K_SEMI, 8'd1);
      CH_APOS: close_token(K_COMMA, 8'd1);
      CH_LPAREN: close_token(K_LPAREN, 8'd1);
      CH_RPAREN: close_token(K_RPAREN, 8'd1);
      CH_LBRACE: close_token(K_LBRACE, 8'd1);
      CH_RBRACE: close_token(K_RBRACE, 8'd1);
      default: begin
        if (is_letter(c)) open_token(ST_IDENT, c);
        else if (is_digit(c)) open_token(ST_INT, c);
      end
    endcase
  endtask

  // A character that closes an open token without being part of it is handed
  // back through rescan so that it starts the next token.
  task automatic continue_token(logic [7:0] c, output bit rescan);
    logic [7:0] len;
    logic [7:0] longer;
    len = length_q;
    longer = (len != 8'd255) ? len + 8'd1 : len;
    rescan = 1'b0;
    case (scan_q)
      ST_INT: begin
        if (is_digit(c)) take_char(c);
        else if (c == CH_DOT) begin
          scan_q = ST_DOT;
          take_char(c);
        end else begin
          close_token(K_INT, len);
          rescan = 1'b1;
        end
      end
      ST_DOT: begin
        if (is_digit(c)) begin
          scan_q = ST_REAL;
          take_char(c);
        end else begin
          close_token(K_ERROR, len);
          rescan = 1'b1;
        end
      end
      ST_REAL: begin
        if (is_digit(c)) take_char(c);
        else begin
          close_token(K_REAL, len);
          rescan = 1'b1;
        end
      end
      ST_REL: begin
        if (c == CH_EQ) close_token(K_REL, longer);
        else begin
          close_token(K_REL, len);
          rescan = 1'b1;
        end
      end
      ST_BAR: begin
        if (c == CH_BAR) close_token(K_OR, longer);
        else begin
          close_token(K_ERROR, len);
          rescan = 1'b1;
        end
      end
      ST_AMP: begin
        if (c == CH_AMP) close_token(K_AND, longer);
        else begin
          close_token(K_ERROR, len);
          rescan = 1'b1;
        end
      end
      ST_NOT: begin
        if (c == CH_EQ) close_token(K_EQUALITY, longer);
        else begin
          close_token(K_NOT, len);
          rescan = 1'b1;
        end
      end
      ST_ASSIGN: begin
        if (c == CH_EQ) close_token(K_EQUALITY, longer);
        else begin
          close_token(K_ASSIGN, len);
          rescan = 1'b1;
        end
      end
      ST_IDENT: begin
        if (is_letter(c) || is_digit(c)) take_char(c);
        else begin
          close_token(keyword_kind(), len);
          rescan = 1'b1;
        end
      end
      ST_QUOTE: begin
        if (is_letter(c) || is_digit(c) || is_blank(c)) begin
          scan_q = ST_STRBODY;
          take_char(c);
        end else begin
          close_token(K_ERROR, len);
          rescan = 1'b1;
        end
      end
      ST_STRBODY: begin
        if (is_letter(c) || is_digit(c) || is_blank(c)) take_char(c);
        else if (c == CH_QUOTE) close_token(K_STRING, longer);
        else begin
          close_token(K_ERROR, len);
          rescan = 1'b1;
        end
      end
      default: begin
        scan_q = ST_START;
        length_q = '0;
        word_q = '0;
        rescan = 1'b1;
      end
    endcase
  endtask

  task automatic predict_tokens(char_word_t w);
    logic [7:0] c;
    bit         rescan;
    c = w.end_of_input ? CH_END : w.character;
    step_tokens = 0;
    rescan = 1'b1;
    if (scan_q != ST_START) continue_token(c, rescan);
    if (rescan) start_token(c);
    if (step_tokens > 0) expected_tokens[expected_tokens.size()-1].last_of_item = 1'b1;
  endtask

  task automatic note_failure(string what);
    failures++;
    if (failures <= SHOWN_MISMATCHES) $display("token %0d: %s", token_index, what);
  endtask

  task automatic check_token(token_t got);
    token_t want;
    if (expected_tokens.size() == 0) begin
      note_failure($sformatf("unexpected word kind %0d length %0d last %0b",
                             got.token_kind, got.token_length, got.last_of_item));
    end else begin
      want = expected_tokens.pop_front();
      if (got.token_kind !== want.token_kind || got.token_length !== want.token_length ||
          got.last_of_item !== want.last_of_item) begin
        note_failure($sformatf("expected kind %0d length %0d last %0b, got kind %0d length %0d last %0b",
                               want.token_kind, want.token_length, want.last_of_item,
                               got.token_kind, got.token_length, got.last_of_item));
      end
    end
    token_index++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      scan_q = ST_START;
      length_q = '0;
      word_q = '0;
      expected_tokens.delete();
    end else begin
      if (char_valid && char_ready) predict_tokens(char_word);
      if (token_valid && token_ready) check_token(token_word);
    end
    fail_count <= failures;
    pending <= expected_tokens.size();
  end

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// Lexer token scanner testbench
// Feeds the scanner a short directed text and then a long random one built
// from well-formed tokens with random content, mixed with broken tokens, end
// markers and stray bytes. Both channels idle at random, with a calm window
// and one long stall on the token side. A checker beside the block predicts
// and compares every token word.
// ----------------------------------------------------------------------------
module tb_top;
  import lts_pkg::*;

  localparam int KEYWORD_CHARS = 6;
  localparam int CHAR_GOAL = 1650;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PERCENT = 22;
  localparam int CALM_FROM = 1300;
  localparam int CALM_TO = 1700;
  localparam int HOLD_AT = 900;
  localparam int HOLD_CYCLES = 120;
  localparam int SETTLE_CYCLES = 20;

  logic       clk;
  logic       rst;
  int         cycle_count = 0;
  int         fail_count;
  int         pending;
  int         counted_chars = 0;
  char_word_t char_stream[$];

  string keyword_texts[7] = '{"int", "float", "void", "if", "while", "return", "else"};
  string operator_texts[20] = '{"+", "-", "*", "/", "<", "<=", ">", ">=", "||", "&&",
                                "!", "!=", "==", "=", ";", "'", "(", ")", "{", "}"};

  lts_if #(.payload_t(char_word_t)) chars_ch ();
  lts_if #(.payload_t(token_t)) tokens_ch ();

  lexer_token_scanner #(.KEYWORD_CHARS(KEYWORD_CHARS)) dut (
    .clk(clk),
    .rst(rst),
    .chars(chars_ch),
    .tokens(tokens_ch)
  );

  lts_token_checker #(.KEYWORD_CHARS(KEYWORD_CHARS)) token_check (
    .clk(clk),
    .rst(rst),
    .char_valid(chars_ch.valid),
    .char_ready(chars_ch.ready),
    .char_word(chars_ch.data),
    .token_valid(tokens_ch.valid),
    .token_ready(tokens_ch.ready),
    .token_word(tokens_ch.data),
    .fail_count(fail_count),
    .pending(pending)
  );

  function automatic bit calm();
    return cycle_count >= CALM_FROM && cycle_count < CALM_TO;
  endfunction

  function automatic logic [7:0] letter_char();
    int r;
    r = $urandom_range(52);
    if (r < 26) return 8'("A" + r);
    if (r < 52) return 8'("a" + r - 26);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] digit_char();
    return 8'("0" + $urandom_range(9));
  endfunction

  function automatic logic [7:0] alnum_char();
    return ($urandom_range(3) == 0) ? digit_char() : letter_char();
  endfunction

  function automatic logic [7:0] blank_char();
    return $urandom_range(1) ? CH_SPACE : CH_TAB;
  endfunction

  task automatic push_char(logic [7:0] c);
    char_stream.push_back('{character: c, end_of_input: 1'b0});
    counted_chars++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  task automatic push_end();
    char_stream.push_back('{character: 8'($urandom_range(255)), end_of_input: 1'b1});
    counted_chars++;
  endtask

  task automatic push_separator();
    logic [7:0] c;
    case ($urandom_range(2))
      0: c = CH_SPACE;
      1: c = CH_TAB;
      default: c = "\n";
    endcase
    char_stream.push_back('{character: c, end_of_input: 1'b0});
    counted_chars++;
  endtask

  task automatic add_broken();
    case ($urandom_range(4))
      0: begin
        repeat ($urandom_range(1, 3)) push_char(digit_char());
        push_char(CH_DOT);
        push_char($urandom_range(1) ? letter_char() : CH_SEMI);
      end
      1: begin
        push_char(CH_BAR);
        push_char(letter_char());
      end
      2: begin
        push_char(CH_AMP);
        push_char(digit_char());
      end
      3: begin
        push_char(CH_QUOTE);
        repeat ($urandom_range(0, 4)) push_char(alnum_char());
        push_char($urandom_range(1) ? 8'($urandom_range(128, 255)) : CH_SEMI);
      end
      default: begin
        push_char(CH_QUOTE);
        push_char(CH_QUOTE);
      end
    endcase
  endtask

  task automatic add_fragment(bit long_name);
    int pick;
    pick = $urandom_range(99);
    if (long_name) begin
      push_char(letter_char());
      repeat ($urandom_range(250, 300)) push_char(alnum_char());
    end else if (pick < 15) begin
      push_text(keyword_texts[$urandom_range(6)]);
      if ($urandom_range(3) == 0) push_char(alnum_char());
    end else if (pick < 30) begin
      push_char(letter_char());
      repeat ($urandom_range(7)) push_char(alnum_char());
    end else if (pick < 40) begin
      repeat ($urandom_range(1, 5)) push_char(digit_char());
    end else if (pick < 48) begin
      repeat ($urandom_range(1, 4)) push_char(digit_char());
      push_char(CH_DOT);
      repeat ($urandom_range(1, 4)) push_char(digit_char());
    end else if (pick < 56) begin
      push_char(CH_QUOTE);
      repeat ($urandom_range(1, 6)) push_char(($urandom_range(3) == 0) ? blank_char() : alnum_char());
      push_char(CH_QUOTE);
    end else if (pick < 76) begin
      push_text(operator_texts[$urandom_range(19)]);
    end else if (pick < 81) begin
      if ($urandom_range(1)) push_end();
      else push_char(CH_END);
    end else if (pick < 91) begin
      add_broken();
    end else begin
      push_char(8'($urandom_range(255)));
    end
  endtask

  task automatic build_stream();
    int fragments;
    push_text("if(a<=9.5&&!b==c||d)'$");
    push_char(8'h00);
    push_char(8'hFF);
    push_end();
    fragments = 0;
    while (counted_chars < CHAR_GOAL) begin
      add_fragment(fragments == 40 || fragments == 260);
      if ($urandom_range(99) < 55) push_separator();
      fragments++;
    end
    push_end();
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int hold_left;
    hold_left = 0;
    tokens_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (cycle_count == HOLD_AT) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        tokens_ch.ready <= 1'b0;
      end else if (calm()) begin
        tokens_ch.ready <= 1'b1;
      end else begin
        tokens_ch.ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  initial begin
    rst = 1'b1;
    chars_ch.valid = 1'b0;
    chars_ch.data = '0;
    build_stream();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (char_stream[i]) begin
      while (!calm() && $urandom_range(99) < IDLE_PERCENT) begin
        chars_ch.valid <= 1'b0;
        @(posedge clk);
      end
      chars_ch.valid <= 1'b1;
      chars_ch.data <= char_stream[i];
      @(posedge clk);
      while (!chars_ch.ready) @(posedge clk);
    end
    chars_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/lts_pkg.sv
rtl/lts_if.sv
rtl/lts_scan.sv
rtl/lts_fifo.sv
rtl/lexer_token_scanner.sv
rtl/lts_checker.sv
test/lts_token_checker.sv
test/tb_top.sv
